/* rtl/sdt_pkg.sv */
// Package for the subset DP total-tardiness block: sizes, payload structs,
// sequencer state type and the control groups passed between modules.
// No dependencies.
package sdt_pkg;

  // Job capacity and derived widths
  localparam int unsigned MaxJobs    = 15;
  localparam int unsigned JobIdxW    = $clog2(MaxJobs);
  localparam int unsigned CountW     = $clog2(MaxJobs + 1);
  localparam int unsigned SetW       = MaxJobs;
  localparam int unsigned TableDepth = 1 << MaxJobs;

  // Field widths
  localparam int unsigned DeadlineW = 16;
  localparam int unsigned DurationW = 16;
  localparam int unsigned TimeW     = DurationW + $clog2(MaxJobs);
  localparam int unsigned LateW     = 24;

  localparam logic [LateW-1:0] LateMax = {LateW{1'b1}};

  // Input request payload
  typedef struct packed {
    logic [DeadlineW-1:0] job_deadline;
    logic [DurationW-1:0] job_duration;
    logic                 last_job;
  } in_item_t;

  // Result request payload
  typedef struct packed {
    logic [LateW-1:0] total_lateness;
    logic             too_many_jobs;
  } out_item_t;

  // DP sequencer states
  typedef enum logic [2:0] {
    E_IDLE,
    E_INIT,
    E_TIME,
    E_TWAIT,
    E_SCAN,
    E_DRAIN,
    E_WRITE,
    E_DONE
  } eng_state_e;

  // Job store status towards the top level
  typedef struct packed {
    logic [CountW-1:0] count_next;
    logic              overflow_next;
  } store_status_t;

  // Start command to the DP engine
  typedef struct packed {
    logic              start;
    logic [CountW-1:0] job_count;
    logic              overflow;
  } eng_start_t;

  // DP engine status
  typedef struct packed {
    logic      idle;
    logic      done;
    out_item_t result;
  } eng_status_t;

endpackage

/* rtl/sdt_job_store.sv */
// Job store: deadline and duration registers, job count and overflow flag.
// Depends on sdt_pkg.
module sdt_job_store import sdt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  logic [DeadlineW-1:0] wr_deadline_i,
  input  logic [DurationW-1:0] wr_duration_i,
  input  logic                 clear_i,
  input  logic [JobIdxW-1:0]   dl_idx_i,
  input  logic [JobIdxW-1:0]   dur_idx_i,
  output logic [DeadlineW-1:0] dl_o,
  output logic [DurationW-1:0] dur_o,
  output store_status_t        status_o
);

  logic [DeadlineW-1:0] dl_mem  [MaxJobs];
  logic [DurationW-1:0] dur_mem [MaxJobs];
  logic [CountW-1:0]    count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic                 full;

  assign full = (count_q == CountW'(MaxJobs));

  // Status as it will stand once the current request is stored
  always_comb begin
    status_o.count_next    = full ? count_q : count_q + CountW'(1);
    status_o.overflow_next = ovf_q | full;
  end

  // Count and overflow next values; clear wins at the end of a set
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (clear_i) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (wr_i) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Job registers, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i && !full) begin
      dl_mem[count_q[JobIdxW-1:0]]  <= wr_deadline_i;
      dur_mem[count_q[JobIdxW-1:0]] <= wr_duration_i;
    end
  end

  assign dl_o  = dl_mem[dl_idx_i];
  assign dur_o = dur_mem[dur_idx_i];

endmodule

/* rtl/sdt_dp_engine.sv */
// Subset DP engine: sequencer, subset time and best lateness tables, and one
// shared lateness add / compare unit. Depends on sdt_pkg.
module sdt_dp_engine import sdt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  eng_start_t           start_i,
  input  logic                 res_free_i,
  input  logic [DeadlineW-1:0] dl_i,
  input  logic [DurationW-1:0] dur_i,
  output logic [JobIdxW-1:0]   dl_idx_o,
  output logic [JobIdxW-1:0]   dur_idx_o,
  output eng_status_t          status_o
);

  eng_state_e state_q, state_d;

  logic [CountW-1:0]  n_q, n_d;
  logic               ovf_q, ovf_d;
  logic [SetW-1:0]    s_q, s_d;
  logic [JobIdxW-1:0] j_q, j_d;
  logic [JobIdxW-1:0] low_q, low_d;
  logic [TimeW-1:0]   t_q, t_d;
  logic [LateW-1:0]   best_q, best_d;
  logic               pv_q, pv_d;
  logic [JobIdxW-1:0] pj_q, pj_d;

  // Tables
  logic [TimeW-1:0] time_mem [TableDepth];
  logic [LateW-1:0] best_mem [TableDepth];
  logic [TimeW-1:0] time_rd_q;
  logic [LateW-1:0] best_rd_q;

  logic             time_re, time_we, best_re, best_we;
  logic [SetW-1:0]  time_raddr, time_waddr, best_raddr, best_waddr;
  logic [TimeW-1:0] time_wdata;
  logic [LateW-1:0] best_wdata;

  logic [SetW-1:0]    full_set;
  logic [SetW-1:0]    low_oh;
  logic [JobIdxW-1:0] low_idx;
  logic               last_j;
  logic [TimeW-1:0]   t_new;
  logic [TimeW-1:0]   late;
  logic [LateW:0]     sum;
  logic [LateW-1:0]   cand;
  logic               take;

  assign full_set = ~({SetW{1'b1}} << n_q);
  assign last_j   = (j_q == JobIdxW'(n_q - CountW'(1)));

  // Lowest job of the subset: isolate lowest set bit, then encode
  assign low_oh = s_q & ~(s_q - SetW'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < SetW; i++) begin
      if (low_oh[i]) begin
        low_idx = low_idx | JobIdxW'(i);
      end
    end
  end

  // Subset time from the subset without its lowest job
  assign t_new = time_rd_q + TimeW'(dur_i);

  // Shared lateness unit: floor(t - d, 0) plus best of the smaller subset
  assign late = (t_q > TimeW'(dl_i)) ? (t_q - TimeW'(dl_i)) : '0;
  assign sum  = {1'b0, best_rd_q} + (LateW + 1)'(late);
  assign cand = sum[LateW] ? LateMax : sum[LateW-1:0];
  assign take = pv_q && (cand < best_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      E_IDLE:  if (start_i.start) state_d = E_INIT;
      E_INIT: begin
        if (full_set == '0) state_d = E_DONE;
        else                state_d = E_TIME;
      end
      E_TIME:  state_d = E_TWAIT;
      E_TWAIT: state_d = E_SCAN;
      E_SCAN:  if (last_j) state_d = E_DRAIN;
      E_DRAIN: state_d = E_WRITE;
      E_WRITE: begin
        if (s_q == full_set) state_d = E_DONE;
        else                 state_d = E_TIME;
      end
      E_DONE:  if (res_free_i) state_d = E_IDLE;
      default: state_d = E_IDLE;
    endcase
  end

  // Datapath register next values
  always_comb begin
    n_d    = n_q;
    ovf_d  = ovf_q;
    s_d    = s_q;
    j_d    = j_q;
    low_d  = low_q;
    t_d    = t_q;
    best_d = best_q;
    pv_d   = 1'b0;
    pj_d   = pj_q;
    unique case (state_q)
      E_IDLE: begin
        if (start_i.start) begin
          n_d   = start_i.job_count;
          ovf_d = start_i.overflow;
        end
      end
      E_INIT: begin
        s_d    = SetW'(1);
        best_d = '0;
      end
      E_TIME:  low_d = low_idx;
      E_TWAIT: begin
        t_d    = t_new;
        j_d    = '0;
        best_d = LateMax;
      end
      E_SCAN: begin
        pv_d = s_q[j_q];
        pj_d = j_q;
        j_d  = j_q + JobIdxW'(1);
        if (take) best_d = cand;
      end
      E_DRAIN: if (take) best_d = cand;
      E_WRITE: if (s_q != full_set) s_d = s_q + SetW'(1);
      E_DONE:  ;
      default: ;
    endcase
  end

  // Memory control and status outputs
  always_comb begin
    time_re    = (state_q == E_TIME);
    time_raddr = s_q & (s_q - SetW'(1));
    time_we    = 1'b0;
    time_waddr = s_q;
    time_wdata = t_new;
    best_re    = (state_q == E_SCAN) && s_q[j_q];
    best_raddr = s_q ^ (SetW'(1) << j_q);
    best_we    = 1'b0;
    best_waddr = s_q;
    best_wdata = best_q;
    unique case (state_q)
      E_INIT: begin
        time_we    = 1'b1;
        time_waddr = '0;
        time_wdata = '0;
        best_we    = 1'b1;
        best_waddr = '0;
        best_wdata = '0;
      end
      E_TWAIT: time_we = 1'b1;
      E_WRITE: best_we = 1'b1;
      default: ;
    endcase
    dl_idx_o  = pj_q;
    dur_idx_o = low_q;
    status_o.idle                  = (state_q == E_IDLE);
    status_o.done                  = (state_q == E_DONE);
    status_o.result.total_lateness = best_q;
    status_o.result.too_many_jobs  = ovf_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    ovf_q  <= ovf_d;
    s_q    <= s_d;
    j_q    <= j_d;
    low_q  <= low_d;
    t_q    <= t_d;
    best_q <= best_d;
    pj_q   <= pj_d;
  end

  // Subset time table
  always_ff @(posedge clk_i) begin
    if (time_we) time_mem[time_waddr] <= time_wdata;
    if (time_re) time_rd_q <= time_mem[time_raddr];
  end

  // Best lateness table
  always_ff @(posedge clk_i) begin
    if (best_we) best_mem[best_waddr] <= best_wdata;
    if (best_re) best_rd_q <= best_mem[best_raddr];
  end

endmodule

/* rtl/subset_dp_min_total_tardiness.sv */
// Top level of the subset DP minimum total tardiness block: handshake,
// job store, DP engine and result register. Depends on sdt_pkg.
//
//  channel | dir | payload     | handshake
//  --------+-----+-------------+-------------------------
//  in      | in  | in_item_t   | in_valid_i / in_ready_o
//  out     | out | out_item_t  | out_valid_o / out_ready_i
//
// A request without last_job is stored in the job store. A request with
// last_job starts the DP over the n stored jobs. For each subset, the best
// lateness table is scanned once per job through its single read port.
// No clearing pass after reset; tables are written before they are read.
// Input is refused while the DP runs, and a finished result waits in the
// engine until the output register is free.
module subset_dp_min_total_tardiness import sdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic                 in_accept;
  logic                 res_free;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q;
  store_status_t        store_status;
  eng_start_t           eng_start;
  eng_status_t          eng_status;
  logic [DeadlineW-1:0] dl;
  logic [DurationW-1:0] dur;
  logic [JobIdxW-1:0]   dl_idx;
  logic [JobIdxW-1:0]   dur_idx;

  assign in_ready_o = eng_status.idle;
  assign in_accept  = in_valid_i && in_ready_o;
  assign res_free   = !out_valid_q || out_ready_i;

  // Start the DP on the closing request
  always_comb begin
    eng_start.start     = in_accept && in_item_i.last_job;
    eng_start.job_count = store_status.count_next;
    eng_start.overflow  = store_status.overflow_next;
  end

  sdt_job_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (in_accept),
    .wr_deadline_i (in_item_i.job_deadline),
    .wr_duration_i (in_item_i.job_duration),
    .clear_i       (eng_start.start),
    .dl_idx_i      (dl_idx),
    .dur_idx_i     (dur_idx),
    .dl_o          (dl),
    .dur_o         (dur),
    .status_o      (store_status)
  );

  sdt_dp_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (eng_start),
    .res_free_i (res_free),
    .dl_i       (dl),
    .dur_i      (dur),
    .dl_idx_o   (dl_idx),
    .dur_idx_o  (dur_idx),
    .status_o   (eng_status)
  );

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_status.done && res_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (eng_status.done && res_free) out_item_q <= eng_status.result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* test/subset_dp_min_total_tardiness_check.sv */
`timescale 1ns / 1ps
// Checker for the subset DP total-tardiness block. It watches both request
// channels, predicts each set's result and compares it. Depends on sdt_pkg.
module tardiness_set_checker import sdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        pending_o,
  output int        errors_o
);

  // Jobs of the set being collected
  logic [DeadlineW-1:0] set_deadline [MaxJobs];
  logic [DurationW-1:0] set_duration [MaxJobs];
  int unsigned          set_count;
  logic                 set_overflow;

  // DP tables, one entry per subset bitmask
  int unsigned subset_time [TableDepth];
  int unsigned subset_late [TableDepth];

  // Results still owed by the block, oldest first
  out_item_t lateness_due_q [$];
  int        error_count;

  // Least summed lateness over every order of the first n stored jobs
  function automatic int unsigned min_total_lateness(input int unsigned n);
    int unsigned full_set;
    int unsigned low;
    int unsigned t;
    int unsigned late;
    int unsigned cand;
    int unsigned best;
    bit          have;
    full_set = (32'd1 << n) - 32'd1;
    subset_time[0] = 0;
    subset_late[0] = 0;
    for (int unsigned s = 1; s <= full_set; s++) begin
      // subset time: subset without its lowest job, plus that job
      low = 0;
      while (((s >> low) & 32'd1) == 32'd0) low++;
      t = subset_time[s ^ (32'd1 << low)] + set_duration[low];
      subset_time[s] = t;
      // try each member as the job finishing last
      have = 1'b0;
      best = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (((s >> j) & 32'd1) != 32'd0) begin
          late = (t > set_deadline[j]) ? t - set_deadline[j] : 32'd0;
          cand = subset_late[s ^ (32'd1 << j)] + late;
          if (!have || cand < best) begin
            best = cand;
            have = 1'b1;
          end
        end
      end
      subset_late[s] = best;
    end
    return subset_late[full_set];
  endfunction

  // Sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t   due;
    out_item_t   predicted;
    int unsigned total;
    if (!rst_ni) begin
      set_count    = 0;
      set_overflow = 1'b0;
      lateness_due_q.delete();
      error_count  = 0;
      pending_o    = 0;
      errors_o     = 0;
    end else begin
      // result side first; an expectation made this cycle is not due yet
      if (out_valid_i && out_ready_i) begin
        if (lateness_due_q.size() == 0) begin
          $error("result with none expected: total_lateness %0d, too_many_jobs %0b",
                 out_item_i.total_lateness, out_item_i.too_many_jobs);
          error_count++;
        end else begin
          due = lateness_due_q.pop_front();
          if (out_item_i.total_lateness !== due.total_lateness) begin
            $error("total_lateness: expected %0d, got %0d",
                   due.total_lateness, out_item_i.total_lateness);
            error_count++;
          end
          if (out_item_i.too_many_jobs !== due.too_many_jobs) begin
            $error("too_many_jobs: expected %0b, got %0b",
                   due.too_many_jobs, out_item_i.too_many_jobs);
            error_count++;
          end
        end
      end
      // request side: store the job or drop it when full
      if (in_valid_i && in_ready_i) begin
        if (set_count < MaxJobs) begin
          set_deadline[set_count] = in_item_i.job_deadline;
          set_duration[set_count] = in_item_i.job_duration;
          set_count++;
        end else begin
          set_overflow = 1'b1;
        end
        // closing job: solve the set and start a new one
        if (in_item_i.last_job) begin
          total = min_total_lateness(set_count);
          if (total > LateMax) total = LateMax;
          predicted.total_lateness = total[LateW-1:0];
          predicted.too_many_jobs  = set_overflow;
          lateness_due_q.push_back(predicted);
          set_count    = 0;
          set_overflow = 1'b0;
        end
      end
      pending_o = lateness_due_q.size();
      errors_o  = error_count;
    end
  end

endmodule

/* test/subset_dp_min_total_tardiness_test.sv */
`timescale 1ns / 1ps
// Testbench top for subset_dp_min_total_tardiness: clock, reset, request
// stimulus and verdict. Depends on sdt_pkg and tardiness_set_checker.
module subset_dp_min_total_tardiness_test import sdt_pkg::*;;

  localparam int CycleLimit   = 4_000_000;
  localparam int LongHold     = 20_000;
  localparam int SettleCycles = 200;
  localparam int PhaseJobs    = 16;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int pending_jobs;
  int error_total;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  always #2 clk = ~clk;

  subset_dp_min_total_tardiness i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  tardiness_set_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .pending_o   (pending_jobs),
    .errors_o    (error_total)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Idle cycles before the next request
  function automatic int sender_gap();
    int gap;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < idle_pct) gap++;
    return gap;
  endfunction

  // Offer one job and hold it until accepted
  task automatic offer_job(input logic [DeadlineW-1:0] deadline,
                           input logic [DurationW-1:0] duration,
                           input logic                 last);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid              = 1'b1;
    in_item.job_deadline  = deadline;
    in_item.job_duration  = duration;
    in_item.last_job      = last;
    do @(posedge clk); while (!in_ready);
  endtask

  // One set of n jobs: either full-range values or tight ones where order matters
  task automatic send_random_set(input int n);
    bit                   tight;
    logic [DeadlineW-1:0] deadline;
    logic [DurationW-1:0] duration;
    tight = 1'($urandom_range(1));
    for (int k = 0; k < n; k++) begin
      if (tight) begin
        duration = DurationW'($urandom_range(60));
        deadline = DeadlineW'($urandom_range(40 * n));
      end else begin
        duration = DurationW'($urandom);
        deadline = DeadlineW'($urandom);
      end
      offer_job(deadline, duration, k == n - 1);
    end
  endtask

  // Stop offering until every owed result has come
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_jobs != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int n;
    in_valid = 1'b0;
    in_item  = '0;
    rst_n    = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // single-job sets at the field extremes
    offer_job(16'h0000, 16'h0000, 1'b1);
    offer_job(16'h0000, 16'hFFFF, 1'b1);
    offer_job(16'hFFFF, 16'hFFFF, 1'b1);
    offer_job(16'hFFFF, 16'h0000, 1'b1);
    // small set where the order decides the lateness
    offer_job(16'd4, 16'd3, 1'b0);
    offer_job(16'd2, 16'd6, 1'b0);
    offer_job(16'd9, 16'd1, 1'b1);
    // too many jobs: the sixteenth and the closing job are dropped,
    // the stored fifteen give the largest sums
    for (int k = 0; k < 16; k++) offer_job(16'(k * 4096), 16'hFFFF, 1'b0);
    offer_job(16'hFFFF, 16'h0000, 1'b1);
    wait_for_results();

    // receiver holds off while sets keep coming, so the input stalls
    hold_requests++;
    repeat (4) send_random_set($urandom_range(4, 2));
    wait_for_results();

    // random sets under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 86;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 86;
        end
        default: begin
          idle_pct  = 8;
          stall_pct = 8;
        end
      endcase
      sent = 0;
      while (sent < PhaseJobs) begin
        if ($urandom_range(7) == 0) n = $urandom_range(9, 7);
        else n = $urandom_range(5, 1);
        send_random_set(n);
        sent += n;
      end
      wait_for_results();
    end

    // let any stray result show up before the verdict
    repeat (SettleCycles) @(negedge clk);
    if (error_total == 0 && pending_jobs == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sdt_pkg.sv
rtl/sdt_job_store.sv
rtl/sdt_dp_engine.sv
rtl/subset_dp_min_total_tardiness.sv
test/subset_dp_min_total_tardiness_check.sv
test/subset_dp_min_total_tardiness_test.sv
